// File: hw/rtl/gisc_pkg.sv
package gisc_pkg;

  // Field widths of the channels and the configuration register
  localparam int MASK_W  = 12;
  localparam int COUNT_W = 27;
  localparam int CFG_W   = 4;

  // Defaults
  localparam int MAX_WIDTH_DEF = 12;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = CFG_W'(12);

  // Counts are kept modulo this value
  localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(100000000);

endpackage

// File: hw/rtl/gisc_if.sv
interface gisc_row_if;
  logic                        valid;
  logic                        ready;
  logic [gisc_pkg::MASK_W-1:0] usable_mask;
  logic                        last_row;

  modport source (output valid, output usable_mask, output last_row, input ready);
  modport sink   (input valid, input usable_mask, input last_row, output ready);
endinterface

interface gisc_count_if;
  logic                         valid;
  logic                         ready;
  logic [gisc_pkg::COUNT_W-1:0] placement_count;

  modport source (output valid, output placement_count, input ready);
  modport sink   (input valid, input placement_count, output ready);
endinterface

// File: hw/rtl/gisc_add_mod.sv
module gisc_add_mod (
  input  logic [gisc_pkg::COUNT_W-1:0] a,
  input  logic [gisc_pkg::COUNT_W-1:0] b,
  output logic [gisc_pkg::COUNT_W-1:0] sum
);

  logic [gisc_pkg::COUNT_W:0] raw;

  // Both operands stay below the modulus, so one conditional subtract folds the sum
  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    if (raw >= {1'b0, gisc_pkg::COUNT_MOD}) begin
      raw = raw - {1'b0, gisc_pkg::COUNT_MOD};
    end
    sum = raw[gisc_pkg::COUNT_W-1:0];
  end

endmodule

// File: hw/rtl/gisc_count_mem.sv
module gisc_count_mem #(
  parameter int ADDR_W = gisc_pkg::MAX_WIDTH_DEF + 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [gisc_pkg::COUNT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [gisc_pkg::COUNT_W-1:0] rd_data
);

  logic [gisc_pkg::COUNT_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/grid_independent_set_counter.sv
// Channel     Dir  Beat payload                      Accepted when
// ----------  ---  --------------------------------  ----------------------------
// row_in      in   usable_mask[11:0], last_row       row_in.valid & row_in.ready
// count_out   out  placement_count[26:0]             count_out.valid & count_out.ready
// cfg_wr_*    in   cfg_wr_data[3:0] (row_width)      cfg_wr_en
//
// One row beat is taken only in idle. The row then walks all 2^MAX_WIDTH patterns,
// each with a start and a write step; for each legal p after a grid's first row, the
// 2^(w - popcount(p)) previous-row entries over its free cells are read and summed
// through the shared modular adder in read and drain steps. Synchronous reset starts a fresh
// grid and sets row_width to 12; the tables need no clearing, as a first row never reads
// them. A result waits in its own register; only the final pattern of a later grid holds.
module grid_independent_set_counter #(
  parameter int MAX_WIDTH = gisc_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  gisc_row_if.sink                   row_in,
  gisc_count_if.source               count_out,
  input  logic                       cfg_wr_en,
  input  logic [gisc_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int ADDR_W = MAX_WIDTH + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_READ  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state;

  logic [gisc_pkg::CFG_W-1:0]   row_width;
  logic [MAX_WIDTH-1:0]         usable;       // latched mask, cut to width
  logic                         last;         // latched last_row flag
  logic                         first_row;    // previous table is the start state
  logic                         wr_bank;      // bank written by the current row
  logic [MAX_WIDTH-1:0]         p;            // pattern being built
  logic [MAX_WIDTH-1:0]         k;            // subset walk over free cells
  logic [MAX_WIDTH-1:0]         free_cells;
  logic                         rd_pending;
  logic [gisc_pkg::COUNT_W-1:0] acc;
  logic [gisc_pkg::COUNT_W-1:0] total;
  logic                         out_valid;
  logic [gisc_pkg::COUNT_W-1:0] out_count;

  logic [MAX_WIDTH-1:0]               full;
  logic [MAX_WIDTH+gisc_pkg::MASK_W-1:0] mask_ext;
  logic                               legal;
  logic                               finish;
  logic                               stall;
  logic [gisc_pkg::COUNT_W-1:0]       add_a;
  logic [gisc_pkg::COUNT_W-1:0]       add_b;
  logic [gisc_pkg::COUNT_W-1:0]       add_sum;
  logic [gisc_pkg::COUNT_W-1:0]       rd_data;
  logic                               mem_we;

  // Cells below row_width; values above MAX_WIDTH saturate by themselves
  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      full[j] = (32'(j) < 32'(row_width));
    end
  end

  assign mask_ext = {{MAX_WIDTH{1'b0}}, row_in.usable_mask};

  // Pattern fits the usable cells and has no two neighbors chosen
  assign legal  = ((p & ~usable) == '0) && ((p & (p << 1)) == '0);
  assign finish = (p == {MAX_WIDTH{1'b1}});
  assign stall  = finish && last && out_valid && !count_out.ready;

  // Shared adder: total update in the write step, accumulation otherwise
  always_comb begin
    if (state == S_WRITE) begin
      add_a = total;
      add_b = acc;
    end else begin
      add_a = acc;
      add_b = rd_data;
    end
  end

  gisc_add_mod u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  assign mem_we = (state == S_WRITE) && !stall;

  gisc_count_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr ({wr_bank, p}),
    .wr_data (acc),
    .rd_addr ({~wr_bank, k}),
    .rd_data (rd_data)
  );

  assign row_in.ready              = (state == S_IDLE);
  assign count_out.valid           = out_valid;
  assign count_out.placement_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= gisc_pkg::ROW_WIDTH_RST;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first_row  <= 1'b1;
      wr_bank    <= 1'b0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= (state == S_READ);
      if (count_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (row_in.valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          // Illegal patterns and first rows need no reads
          if (legal && !first_row) begin
            state <= S_READ;
          end else begin
            state <= S_WRITE;
          end
        end
        S_READ: begin
          if (k == '0) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (!stall) begin
            if (finish) begin
              state     <= S_IDLE;
              wr_bank   <= ~wr_bank;
              first_row <= last;
              if (last) begin
                out_valid <= 1'b1;
              end
            end else begin
              state <= S_START;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (row_in.valid) begin
          usable <= mask_ext[MAX_WIDTH-1:0] & full;
          last   <= row_in.last_row;
          p      <= '0;
          total  <= '0;
        end
      end
      S_START: begin
        free_cells <= full ^ p;
        k          <= full ^ p;
        acc        <= (legal && first_row) ? gisc_pkg::COUNT_W'(1) : '0;
      end
      S_READ: begin
        // Advance to the next smaller subset of the free cells
        k <= (k - 1'b1) & free_cells;
        if (rd_pending) begin
          acc <= add_sum;
        end
      end
      S_DRAIN: begin
        if (rd_pending) begin
          acc <= add_sum;
        end
      end
      S_WRITE: begin
        if (!stall) begin
          total <= add_sum;
          p     <= p + 1'b1;
          if (finish && last) begin
            out_count <= add_sum;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
